[hw/rtl/lhm_pkg.sv]
package lhm_pkg;

  localparam int unsigned DEF_TUNNEL_DEPTH = 8;
  localparam int unsigned DEF_FULL_DEPTH   = 8;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PATH_W   = 26;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned STALE_W  = 31;

  localparam logic [TIME_W-1:0]  LOST_RESET  = 32'd1000;
  localparam logic [STALE_W-1:0] STALE_RESET = 31'd1000;

  typedef enum logic [2:0] {
    FUNC_GROUND = 3'd0,
    FUNC_TUNNEL = 3'd1,
    FUNC_FULL   = 3'd2,
    FUNC_RADIO  = 3'd3,
    FUNC_QUERY  = 3'd4
  } func_e;

  typedef enum logic {
    REG_LOST_TIMEOUT  = 1'b0,
    REG_STALE_TIMEOUT = 1'b1
  } reg_e;

  // status flags captured when a transaction is accepted
  typedef struct packed {
    logic alive;
    logic t_valid;
    logic f_meas;
    logic r_fresh;
  } flags_t;

endpackage

[hw/rtl/lhm_ram.sv]
module lhm_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/link_health_median_monitor.sv]
// Link health monitor. Every accepted event (ground frame, tunnel sample,
// full-path sample, radio status or query) updates the state and returns
// one status transaction. Ages are wrapping 32-bit tick differences. A
// window median is the upper median of the filled entries, found by one
// shared comparator: for each candidate entry the window is swept once and
// entries below / not above the candidate are counted; both windows run
// one after the other. The input is ready only while no event is in work;
// a finished result waits in the output register while a new event is taken.
module link_health_median_monitor #(
  parameter int unsigned TUNNEL_DEPTH = lhm_pkg::DEF_TUNNEL_DEPTH,
  parameter int unsigned FULL_DEPTH   = lhm_pkg::DEF_FULL_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // event channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [31:0] now_time_i,
  input  logic [15:0] byte_count_i,
  input  logic [23:0] sample_us_i,
  input  logic signed [23:0] offset_us_i,
  // status channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        link_alive_o,
  output logic        tunnel_valid_o,
  output logic [23:0] tunnel_median_us_o,
  output logic        full_measured_o,
  output logic        path_valid_o,
  output logic signed [25:0] path_us_o,
  output logic        radio_fresh_o,
  output logic [31:0] rx_total_o,
  output logic [31:0] frame_total_o
);

  localparam int unsigned MAXD = (TUNNEL_DEPTH > FULL_DEPTH) ? TUNNEL_DEPTH : FULL_DEPTH;
  localparam int unsigned TAW  = (TUNNEL_DEPTH > 1) ? $clog2(TUNNEL_DEPTH) : 1;
  localparam int unsigned FAW  = (FULL_DEPTH > 1) ? $clog2(FULL_DEPTH) : 1;
  localparam int unsigned IW   = (MAXD > 1) ? $clog2(MAXD) : 1;
  localparam int unsigned CW   = $clog2(MAXD + 1);
  localparam int unsigned TFW  = $clog2(TUNNEL_DEPTH + 1);
  localparam int unsigned FFW  = $clog2(FULL_DEPTH + 1);
  localparam int unsigned SW   = lhm_pkg::SAMPLE_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_CAND, S_LD_CAND, S_CMP, S_EVAL, S_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [31:0] lost_q;
  logic [30:0] stale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_q  <= lhm_pkg::LOST_RESET;
      stale_q <= lhm_pkg::STALE_RESET;
    end else if (cfg_we_i) begin
      case (lhm_pkg::reg_e'(cfg_idx_i))
        lhm_pkg::REG_LOST_TIMEOUT:  lost_q  <= cfg_data_i;
        lhm_pkg::REG_STALE_TIMEOUT: stale_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // link state
  logic            heard_q, radio_q;
  logic [31:0]     t_ground_q, t_tunnel_q, t_full_q, t_radio_q;
  logic [31:0]     bytes_q, frames_q;
  logic [TAW-1:0]  t_head_q;
  logic [FAW-1:0]  f_head_q;
  logic [TFW-1:0]  t_fill_q;
  logic [FFW-1:0]  f_fill_q;

  logic            heard_d, radio_d;
  logic [31:0]     t_ground_d, t_tunnel_d, t_full_d, t_radio_d;
  logic [31:0]     bytes_d, frames_d;
  logic [TAW-1:0]  t_head_d;
  logic [FAW-1:0]  f_head_d;
  logic [TFW-1:0]  t_fill_d;
  logic [FFW-1:0]  f_fill_d;
  logic            t_we, f_we;

  logic accept;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    heard_d    = heard_q;
    radio_d    = radio_q;
    t_ground_d = t_ground_q;
    t_tunnel_d = t_tunnel_q;
    t_full_d   = t_full_q;
    t_radio_d  = t_radio_q;
    bytes_d    = bytes_q;
    frames_d   = frames_q;
    t_head_d   = t_head_q;
    f_head_d   = f_head_q;
    t_fill_d   = t_fill_q;
    f_fill_d   = f_fill_q;
    t_we       = 1'b0;
    f_we       = 1'b0;
    case (lhm_pkg::func_e'(func_i))
      lhm_pkg::FUNC_GROUND: begin
        heard_d    = 1'b1;
        t_ground_d = now_time_i;
        bytes_d    = bytes_q + {16'd0, byte_count_i};
        frames_d   = frames_q + 32'd1;
      end
      lhm_pkg::FUNC_TUNNEL: begin
        t_we       = 1'b1;
        t_head_d   = (t_head_q == TAW'(TUNNEL_DEPTH - 1)) ? '0 : t_head_q + TAW'(1);
        if (t_fill_q != TFW'(TUNNEL_DEPTH)) t_fill_d = t_fill_q + TFW'(1);
        t_tunnel_d = now_time_i;
      end
      lhm_pkg::FUNC_FULL: begin
        f_we       = 1'b1;
        f_head_d   = (f_head_q == FAW'(FULL_DEPTH - 1)) ? '0 : f_head_q + FAW'(1);
        if (f_fill_q != FFW'(FULL_DEPTH)) f_fill_d = f_fill_q + FFW'(1);
        t_full_d   = now_time_i;
      end
      lhm_pkg::FUNC_RADIO: begin
        radio_d   = 1'b1;
        t_radio_d = now_time_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heard_q    <= 1'b0;
      radio_q    <= 1'b0;
      t_ground_q <= '0;
      t_tunnel_q <= '0;
      t_full_q   <= '0;
      t_radio_q  <= '0;
      bytes_q    <= '0;
      frames_q   <= '0;
      t_head_q   <= '0;
      f_head_q   <= '0;
      t_fill_q   <= '0;
      f_fill_q   <= '0;
    end else if (accept) begin
      heard_q    <= heard_d;
      radio_q    <= radio_d;
      t_ground_q <= t_ground_d;
      t_tunnel_q <= t_tunnel_d;
      t_full_q   <= t_full_d;
      t_radio_q  <= t_radio_d;
      bytes_q    <= bytes_d;
      frames_q   <= frames_d;
      t_head_q   <= t_head_d;
      f_head_q   <= f_head_d;
      t_fill_q   <= t_fill_d;
      f_fill_q   <= f_fill_d;
    end
  end

  // freshness, evaluated on the updated state at the event's own tick
  lhm_pkg::flags_t flags_d;
  logic [31:0] age_g, age_t, age_f, age_r;

  always_comb begin
    age_g = now_time_i - t_ground_d;
    age_t = now_time_i - t_tunnel_d;
    age_f = now_time_i - t_full_d;
    age_r = now_time_i - t_radio_d;
    flags_d.alive   = heard_d && (age_g < lost_q);
    flags_d.t_valid = (t_fill_d != '0) && (age_t <= {1'b0, stale_q});
    flags_d.f_meas  = (f_fill_d != '0) && (age_f <= {stale_q, 1'b0});
    flags_d.r_fresh = radio_d && (age_r < {1'b0, stale_q});
  end

  // sample windows
  logic [IW-1:0]  i_q, j_q;
  logic           sel_full_q;
  logic [IW-1:0]  raddr;
  logic [SW-1:0]  t_rdata, f_rdata, rdata;

  always_comb begin
    case (state_q)
      S_RD_CAND: raddr = i_q;
      S_CMP:     raddr = j_q + IW'(1);
      default:   raddr = '0;
    endcase
  end

  lhm_ram #(.WIDTH(SW), .DEPTH(TUNNEL_DEPTH)) u_tunnel_ram (
    .clk_i   (clk_i),
    .we_i    (accept && t_we),
    .waddr_i (t_head_q),
    .wdata_i (sample_us_i),
    .raddr_i (raddr[TAW-1:0]),
    .rdata_o (t_rdata)
  );

  lhm_ram #(.WIDTH(SW), .DEPTH(FULL_DEPTH)) u_full_ram (
    .clk_i   (clk_i),
    .we_i    (accept && f_we),
    .waddr_i (f_head_q),
    .wdata_i (sample_us_i),
    .raddr_i (raddr[FAW-1:0]),
    .rdata_o (f_rdata)
  );

  assign rdata = sel_full_q ? f_rdata : t_rdata;

  // median sequencer: candidate i, sweep j, shared compare
  lhm_pkg::flags_t flags_q;
  logic [CW-1:0]  n_q, lt_q, le_q;
  logic [SW-1:0]  cand_q, tmed_q, fmed_q;
  logic signed [23:0] off_q;
  logic [CW-1:0]  k;
  logic           last_j, found;

  assign k      = n_q >> 1;
  assign last_j = (CW'(j_q) == n_q - CW'(1));
  assign found  = (lt_q <= k) && (k < le_q);

  logic out_free;
  assign out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      out_valid_o        <= 1'b0;
      sel_full_q         <= 1'b0;
      i_q                <= '0;
      j_q                <= '0;
      n_q                <= '0;
      lt_q               <= '0;
      le_q               <= '0;
      flags_q            <= '0;
      cand_q             <= '0;
      tmed_q             <= '0;
      fmed_q             <= '0;
      off_q              <= '0;
      link_alive_o       <= 1'b0;
      tunnel_valid_o     <= 1'b0;
      tunnel_median_us_o <= '0;
      full_measured_o    <= 1'b0;
      path_valid_o       <= 1'b0;
      path_us_o          <= '0;
      radio_fresh_o      <= 1'b0;
      rx_total_o         <= '0;
      frame_total_o      <= '0;
    end else begin
      // a new result in the done state replaces the one being taken
      if (out_valid_o && out_ready_i && (state_q != S_DONE)) out_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            flags_q <= flags_d;
            off_q   <= offset_us_i;
            tmed_q  <= '0;
            i_q     <= '0;
            if (flags_d.t_valid) begin
              sel_full_q <= 1'b0;
              n_q        <= CW'(t_fill_d);
              state_q    <= S_RD_CAND;
            end else if (flags_d.f_meas) begin
              sel_full_q <= 1'b1;
              n_q        <= CW'(f_fill_d);
              state_q    <= S_RD_CAND;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_RD_CAND: state_q <= S_LD_CAND;
        S_LD_CAND: begin
          cand_q  <= rdata;
          j_q     <= '0;
          lt_q    <= '0;
          le_q    <= '0;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (rdata < cand_q) lt_q <= lt_q + CW'(1);
          if (rdata <= cand_q) le_q <= le_q + CW'(1);
          if (last_j) state_q <= S_EVAL;
          else begin
            j_q     <= j_q + IW'(1);
            state_q <= S_CMP;
          end
        end
        S_EVAL: begin
          if (found) begin
            i_q <= '0;
            if (!sel_full_q) begin
              tmed_q <= cand_q;
              if (flags_q.f_meas) begin
                sel_full_q <= 1'b1;
                n_q        <= CW'(f_fill_q);
                state_q    <= S_RD_CAND;
              end else begin
                state_q <= S_DONE;
              end
            end else begin
              fmed_q  <= cand_q;
              state_q <= S_DONE;
            end
          end else begin
            i_q     <= i_q + IW'(1);
            state_q <= S_RD_CAND;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_o        <= 1'b1;
            link_alive_o       <= flags_q.alive;
            tunnel_valid_o     <= flags_q.t_valid;
            tunnel_median_us_o <= tmed_q;
            full_measured_o    <= flags_q.f_meas;
            path_valid_o       <= flags_q.f_meas || flags_q.t_valid;
            if (flags_q.f_meas) path_us_o <= $signed({2'b00, fmed_q});
            else if (flags_q.t_valid)
              path_us_o <= $signed({2'b00, tmed_q}) + 26'(off_q);
            else path_us_o <= '0;
            radio_fresh_o      <= flags_q.r_fresh;
            rx_total_o         <= bytes_q;
            frame_total_o      <= frames_q;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_full_implies_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && full_measured_o |-> path_valid_o)
    else $error("full path measured without a path estimate");
  a_no_path_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !path_valid_o |-> path_us_o == '0)
    else $error("path delay nonzero without an estimate");
  a_no_tunnel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tunnel_valid_o |-> tunnel_median_us_o == '0)
    else $error("tunnel median nonzero while not valid");
`endif

endmodule

[tb/sv/tb_top.sv]
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN_DEPTH = 8;
  localparam int unsigned N_RANDOM = 730;
  localparam int unsigned STALL_LIMIT = 20000;

  // one expected status transaction
  typedef struct {
    logic        alive;
    logic        t_valid;
    logic [23:0] t_med;
    logic        f_meas;
    logic        p_valid;
    logic [25:0] path;
    logic        r_fresh;
    logic [31:0] rx_total;
    logic [31:0] frame_total;
  } status_t;

  // scoreboard: mirror of the monitor state plus the queue of pending status
  class link_status_board;
    logic [31:0] lost_to;
    logic [30:0] stale_to;
    logic        heard;
    logic [31:0] ground_t, bytes, frames;
    logic [23:0] tun_win[WIN_DEPTH];
    int unsigned tun_head, tun_fill;
    logic [31:0] tun_t;
    logic [23:0] full_win[WIN_DEPTH];
    int unsigned full_head, full_fill;
    logic [31:0] full_t;
    logic        radio;
    logic [31:0] radio_t;
    status_t     pending[$];
    int unsigned mismatches;

    function void clear();
      lost_to = lhm_pkg::LOST_RESET;
      stale_to = lhm_pkg::STALE_RESET;
      heard = 0; ground_t = 0; bytes = 0; frames = 0;
      tun_head = 0; tun_fill = 0; tun_t = 0;
      full_head = 0; full_fill = 0; full_t = 0;
      radio = 0; radio_t = 0;
      mismatches = 0;
    endfunction

    function void write_reg(lhm_pkg::reg_e idx, logic [31:0] val);
      if (idx == lhm_pkg::REG_LOST_TIMEOUT) lost_to = val;
      else stale_to = val[30:0];
    endfunction

    // upper median of the first n entries, by sorting
    function logic [23:0] upper_mid(logic [23:0] w[WIN_DEPTH], int unsigned n);
      logic [23:0] s[$];
      for (int i = 0; i < n; i++) s.push_back(w[i]);
      s.sort();
      return s[n / 2];
    endfunction

    function void note_event(logic [2:0] fn, logic [31:0] now, logic [15:0] nb,
                             logic [23:0] smp, logic signed [23:0] off);
      status_t e;
      logic [32:0] full_age;
      case (fn)
        lhm_pkg::FUNC_GROUND: begin
          heard = 1; ground_t = now; bytes += nb; frames += 1;
        end
        lhm_pkg::FUNC_TUNNEL: begin
          tun_win[tun_head] = smp;
          tun_head = (tun_head + 1) % WIN_DEPTH;
          if (tun_fill < WIN_DEPTH) tun_fill++;
          tun_t = now;
        end
        lhm_pkg::FUNC_FULL: begin
          full_win[full_head] = smp;
          full_head = (full_head + 1) % WIN_DEPTH;
          if (full_fill < WIN_DEPTH) full_fill++;
          full_t = now;
        end
        lhm_pkg::FUNC_RADIO: begin
          radio = 1; radio_t = now;
        end
        default: ;
      endcase
      e.alive = heard && ((now - ground_t) < lost_to);
      e.t_valid = (tun_fill != 0) && ((now - tun_t) <= {1'b0, stale_to});
      e.t_med = e.t_valid ? upper_mid(tun_win, tun_fill) : 24'd0;
      full_age = {1'b0, now - full_t};
      e.f_meas = (full_fill != 0) && (full_age <= {1'b0, stale_to, 1'b0});
      e.p_valid = e.f_meas || e.t_valid;
      if (e.f_meas) e.path = {2'b00, upper_mid(full_win, full_fill)};
      else if (e.t_valid) e.path = {2'b00, e.t_med} + {{2{off[23]}}, off};
      else e.path = '0;
      e.r_fresh = radio && ((now - radio_t) < {1'b0, stale_to});
      e.rx_total = bytes;
      e.frame_total = frames;
      pending.push_back(e);
    endfunction

    function void check_status(status_t got);
      status_t w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected status transaction at %0t", $realtime);
        return;
      end
      w = pending.pop_front();
      if (got.alive !== w.alive || got.t_valid !== w.t_valid || got.t_med !== w.t_med
          || got.f_meas !== w.f_meas || got.p_valid !== w.p_valid || got.path !== w.path
          || got.r_fresh !== w.r_fresh || got.rx_total !== w.rx_total
          || got.frame_total !== w.frame_total) begin
        mismatches++;
        if (mismatches <= 10)
          $display("status mismatch at %0t: exp a%b tv%b tm%h fm%b pv%b p%h rf%b rx%h fr%h / got a%b tv%b tm%h fm%b pv%b p%h rf%b rx%h fr%h",
                   $realtime, w.alive, w.t_valid, w.t_med, w.f_meas, w.p_valid, w.path,
                   w.r_fresh, w.rx_total, w.frame_total, got.alive, got.t_valid,
                   got.t_med, got.f_meas, got.p_valid, got.path, got.r_fresh,
                   got.rx_total, got.frame_total);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] func_i = '0;
  logic [31:0] now_time_i = '0;
  logic [15:0] byte_count_i = '0;
  logic [23:0] sample_us_i = '0;
  logic signed [23:0] offset_us_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic link_alive_o, tunnel_valid_o, full_measured_o, path_valid_o, radio_fresh_o;
  logic [23:0] tunnel_median_us_o;
  logic signed [25:0] path_us_o;
  logic [31:0] rx_total_o, frame_total_o;

  link_status_board board;
  int unsigned idle_cycles = 0;
  bit sink_quiet = 0;    // receiver never stalls
  bit sink_hold = 0;     // request for a long receiver hold-off
  logic [31:0] clock_ms = 0;   // event timestamps march along this

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  link_health_median_monitor u_dut (.*);

  // watchdog on cycles with no accepted transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // compare every status transaction at the rising edge
  always @(posedge clk_i) begin
    status_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.alive = link_alive_o;
      got.t_valid = tunnel_valid_o;
      got.t_med = tunnel_median_us_o;
      got.f_meas = full_measured_o;
      got.p_valid = path_valid_o;
      got.path = path_us_o;
      got.r_fresh = radio_fresh_o;
      got.rx_total = rx_total_o;
      got.frame_total = frame_total_o;
      board.check_status(got);
    end
  end

  // receiver: random stalls, quiet stretches, one long hold-off
  initial begin
    int unsigned hold;
    forever begin
      @(negedge clk_i);
      if (sink_hold) begin
        out_ready_i <= 1'b0;
        hold = 400;
        while (hold > 0) begin
          @(negedge clk_i);
          hold--;
        end
        sink_hold = 0;
      end else begin
        out_ready_i <= sink_quiet || ($urandom_range(99) >= 14);
      end
    end
  end

  task automatic write_cfg(lhm_pkg::reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    board.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offer one event and wait for its acceptance; random gaps before it
  task automatic send_event(logic [2:0] fn, logic [31:0] now, logic [15:0] nb,
                            logic [23:0] smp, logic signed [23:0] off, bit gaps);
    if (gaps) begin
      while ($urandom_range(99) < 14) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    now_time_i <= now;
    byte_count_i <= nb;
    sample_us_i <= smp;
    offset_us_i <= off;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_event(fn, now, nb, smp, off);
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    // the median sweep is already done here; the wait adds margin
    repeat (300) @(negedge clk_i);
  endtask

  // random event whose time mostly moves forward
  task automatic random_event(bit gaps);
    logic [2:0] fn;
    logic [31:0] now;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 2) fn = 3'($urandom_range(7, 5));
    else fn = 3'($urandom_range(4));
    r = $urandom_range(99);
    if (r < 5) now = $urandom();
    else if (r < 10) now = clock_ms - $urandom_range(3000);
    else begin
      clock_ms += $urandom_range(600);
      now = clock_ms;
    end
    r = $urandom_range(9);
    send_event(fn, now, (r == 0) ? 16'hFFFF : 16'($urandom()),
               (r == 1) ? 24'hFFFFFF : ((r < 5) ? 24'($urandom_range(5000))
                                                 : 24'($urandom())),
               24'($urandom()), gaps);
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: queries on empty state, future stamps, extremes
    send_event(lhm_pkg::FUNC_QUERY, 32'd0, 16'd0, 24'd0, 24'sd0, 0);
    send_event(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 24'hFFFFFF, 24'sh7FFFFF, 0);
    send_event(lhm_pkg::FUNC_GROUND, 32'd5, 16'hFFFF, 24'd0, 24'sd0, 0);
    send_event(lhm_pkg::FUNC_RADIO, 32'd6, 16'd0, 24'd0, 24'sd0, 0);
    send_event(lhm_pkg::FUNC_TUNNEL, 32'd7, 16'd0, 24'hFFFFFF, -24'sd8388608, 0);
    send_event(lhm_pkg::FUNC_QUERY, 32'd8, 16'd0, 24'd0, 24'sh7FFFFF, 0);
    send_event(lhm_pkg::FUNC_QUERY, 32'd8, 16'd0, 24'd0, -24'sd8388608, 0);
    for (int i = 0; i < 9; i++)
      send_event(lhm_pkg::FUNC_TUNNEL, 32'd10 + i, 16'd0, 24'(i * 1234567), 24'sd0, 0);
    for (int i = 0; i < 9; i++)
      send_event(lhm_pkg::FUNC_FULL, 32'd20 + i, 16'd0, 24'(16777215 - i * 999), 24'sd0, 0);
    send_event(lhm_pkg::FUNC_QUERY, 32'd1007, 16'd0, 24'd0, 24'sd0, 0);
    send_event(lhm_pkg::FUNC_QUERY, 32'd2028, 16'd0, 24'd0, 24'sd0, 0);
    send_event(lhm_pkg::FUNC_QUERY, 32'd2029, 16'd0, 24'd0, 24'sd0, 0);
    send_event(lhm_pkg::FUNC_QUERY, 32'd3, 16'd0, 24'd0, 24'sd0, 0);

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      go_idle();
      case (ph)
        0: begin
          write_cfg(lhm_pkg::REG_LOST_TIMEOUT, 32'd0);
          write_cfg(lhm_pkg::REG_STALE_TIMEOUT, 32'd0);
        end
        1: begin
          write_cfg(lhm_pkg::REG_LOST_TIMEOUT, 32'hFFFF_FFFF);
          write_cfg(lhm_pkg::REG_STALE_TIMEOUT, 32'h7FFF_FFFF);
        end
        2: begin
          write_cfg(lhm_pkg::REG_LOST_TIMEOUT, 32'd700);
          write_cfg(lhm_pkg::REG_STALE_TIMEOUT, 32'd400);
        end
        3: begin
          write_cfg(lhm_pkg::REG_LOST_TIMEOUT, $urandom_range(3000));
          write_cfg(lhm_pkg::REG_STALE_TIMEOUT, {1'b0, 31'($urandom())});
        end
        default: begin
          write_cfg(lhm_pkg::REG_LOST_TIMEOUT, 32'd1000);
          write_cfg(lhm_pkg::REG_STALE_TIMEOUT, 32'h4000_0000);
        end
      endcase
      sink_quiet = (ph == 2);
      if (ph == 1) sink_hold = 1;   // block fills while the sender keeps going
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        random_event(ph != 2);
        if (ph == 3 && i == 70) begin
          // sender pauses until every status transaction is back
          in_valid_i <= 1'b0;
          while (board.pending.size() != 0) @(negedge clk_i);
        end
      end
    end

    in_valid_i <= 1'b0;
    sink_quiet = 1;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
